@@ sv/pcru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcru_pkg
// Shared types and constants for the predicate compare unit.
// ----------------------------------------------------------------------------
package pcru_pkg;

	localparam int REG_COUNT = 4;
	localparam int REG_IW    = 2;
	localparam int DATA_W    = 8;
	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = 8;
	localparam int IDX_W     = 3;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 16;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CMP   = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMP_EQ = 3'd0,
		CMP_NE = 3'd1,
		CMP_LT = 3'd2,
		CMP_GT = 3'd3,
		CMP_LE = 3'd4,
		CMP_GE = 3'd5
	} cmp_t;

	typedef enum logic [1:0] {
		COMB_REPLACE = 2'd0,
		COMB_AND     = 2'd1,
		COMB_OR      = 2'd2,
		COMB_XOR     = 2'd3
	} comb_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_we;
		logic acc;
		logic wr_do;
		logic a_cap;
		logic sel_b;
		logic exec;
		logic res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic clr_last;
		logic out_free;
	} ctrl_sts_t;

endpackage : pcru_pkg
`default_nettype wire

@@ sv/pcru_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcru_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule : pcru_ram
`default_nettype wire

@@ sv/pcru_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcru_ctrl
// Sequencer: memory clear after reset, then operand fetch and execute steps.
// ----------------------------------------------------------------------------
module pcru_ctrl
	import pcru_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_RDA;
			end
			ST_RDA: begin
				if (sts.op == OP_READ || sts.op == OP_CMP) state_d = ST_RDB;
				else state_d = ST_DONE;
			end
			ST_RDB: begin
				if (sts.op == OP_CMP) state_d = ST_EXEC;
				else state_d = ST_DONE;
			end
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.acc  = s_tvalid;
			end
			ST_RDA:  cmd.wr_do = (sts.op == OP_WRITE);
			ST_RDB: begin
				cmd.a_cap = 1'b1;
				cmd.sel_b = 1'b1;
			end
			ST_EXEC: cmd.exec = 1'b1;
			ST_DONE: cmd.res_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule : pcru_ctrl
`default_nettype wire

@@ sv/pcru_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcru_dp
// Datapath: item latch, general registers, data memory, compare and predicate,
// and the output register.
// ----------------------------------------------------------------------------
module pcru_dp
	import pcru_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata,
	input  wire ctrl_cmd_t        cmd,
	output ctrl_sts_t             sts
);

	op_t                op_q;
	logic [IDX_W-1:0]   tgt_q, first_q, second_q;
	logic [DATA_W-1:0]  wval_q;
	cmp_t               cc_q;
	comb_t              comb_q;

	logic [DATA_W-1:0]  regs_q [REG_COUNT];
	logic               pred_q;
	logic               err_q;
	logic [DATA_W-1:0]  a_q;
	logic [MEM_AW-1:0]  clr_cnt_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_q;

	logic [IDX_W-1:0]   a_idx, b_idx;
	logic [DATA_W-1:0]  a_val, b_val;
	logic [MEM_AW-1:0]  ram_addr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;
	logic               ram_we;
	logic               cmp_bit, cmp_ok;
	logic               pred_d;

	// write and read use the target; compare uses the first operand
	assign a_idx = (op_q == OP_CMP) ? first_q : tgt_q;
	assign b_idx = second_q;

	always_comb begin
		if (cmd.clr_we) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.sel_b) begin
			ram_addr = regs_q[b_idx[REG_IW-1:0]][MEM_AW-1:0];
		end else begin
			ram_addr = regs_q[a_idx[REG_IW-1:0]][MEM_AW-1:0];
		end
	end

	assign ram_we    = cmd.clr_we | (cmd.wr_do & a_idx[IDX_W-1]);
	assign ram_wdata = cmd.clr_we ? '0 : wval_q;

	pcru_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign a_val = a_idx[IDX_W-1] ? ram_rdata : regs_q[a_idx[REG_IW-1:0]];
	assign b_val = b_idx[IDX_W-1] ? ram_rdata : regs_q[b_idx[REG_IW-1:0]];

	always_comb begin
		cmp_ok  = 1'b1;
		cmp_bit = 1'b0;
		case (cc_q)
			CMP_EQ:  cmp_bit = (a_q == b_val);
			CMP_NE:  cmp_bit = (a_q != b_val);
			CMP_LT:  cmp_bit = (a_q <  b_val);
			CMP_GT:  cmp_bit = (a_q >  b_val);
			CMP_LE:  cmp_bit = (a_q <= b_val);
			CMP_GE:  cmp_bit = (a_q >= b_val);
			default: cmp_ok  = 1'b0;
		endcase
	end

	always_comb begin
		case (comb_q)
			COMB_REPLACE: pred_d = cmp_bit;
			COMB_AND:     pred_d = pred_q & cmp_bit;
			COMB_OR:      pred_d = pred_q | cmp_bit;
			COMB_XOR:     pred_d = pred_q ^ cmp_bit;
			default:      pred_d = pred_q;
		endcase
	end

	// item latch, operand A capture and output data: payload only
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			op_q     <= op_t'(s_tdata[1:0]);
			tgt_q    <= s_tdata[4:2];
			wval_q   <= s_tdata[12:5];
			first_q  <= s_tdata[15:13];
			second_q <= s_tdata[18:16];
			cc_q     <= cmp_t'(s_tdata[21:19]);
			comb_q   <= comb_t'(s_tdata[23:22]);
		end
		if (cmd.a_cap) begin
			a_q <= a_val;
		end
		if (cmd.res_load) begin
			out_q <= {6'd0, err_q, pred_q,
				(op_q == OP_READ) ? a_q : {DATA_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
			pred_q      <= 1'b0;
			err_q       <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.wr_do && !a_idx[IDX_W-1]) begin
				regs_q[a_idx[REG_IW-1:0]] <= wval_q;
			end
			if (cmd.acc) begin
				err_q <= 1'b0;
			end
			if (cmd.exec) begin
				err_q <= ~cmp_ok;
				if (cmp_ok) pred_q <= pred_d;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;
	assign sts.op       = op_q;
	assign sts.clr_last = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));
	assign sts.out_free = ~out_valid_q | m_tready;

endmodule : pcru_dp
`default_nettype wire

@@ sv/predicate_compare_register_unit_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// predicate_compare_register_unit_top
// Four byte registers, a 256-byte data memory and a predicate bit, driven by
// write, read and compare beats.
// ----------------------------------------------------------------------------
// After reset the block zeroes its data memory, one byte a cycle, and accepts
// no beat until that pass is done. Each beat is then worked on alone: a write
// or an unused operation passes the first fetch state and then the done state,
// a read adds the second fetch state, a compare also the execute state, as the
// single memory port fetches each memory operand in turn. One more result may
// wait in the output register while the next beat is accepted; a beat finishing
// while that result is still held waits for it to be taken.
module predicate_compare_register_unit_top
	import pcru_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// operation[1:0], target_index[4:2], write_value[12:5], first_operand[15:13],
	// second_operand[18:16], compare_code[21:19], combine_code[23:22]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// read_data[7:0], predicate_now[8], error_code[9], zero[15:10]
	output logic      [OUT_W-1:0] m_tdata
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	pcru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcru_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule : predicate_compare_register_unit_top
`default_nettype wire
